// ===== rtl/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants of the byte ring FIFO with delimited read.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

	localparam int BYTE_W     = 8;
	localparam int CFG_W      = 11;
	localparam int CNT_W      = 7;
	localparam int OP_W       = 3;
	localparam int OUT_FILL_W = 11;
	localparam int CAP_RESET  = 1024;

	// operation codes carried by an input item
	typedef enum logic [OP_W-1:0] {
		OP_PUSH       = 3'd0,
		OP_READ       = 3'd1,
		OP_READ_DELIM = 3'd2,
		OP_DISCARD    = 3'd3,
		OP_UNPUT      = 3'd4
	} op_t;

	// pointer update requested from the pointer unit
	typedef enum logic [2:0] {
		UPD_NONE,
		UPD_PUSH,
		UPD_POP,
		UPD_DISCARD,
		UPD_UNPUT
	} upd_t;

	typedef struct packed {
		upd_t             kind;
		logic [CNT_W-1:0] n;
	} ptr_cmd_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_READ
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/byte_ring_fifo_with_delimiter_read_unit.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_delimiter_read_unit
// Byte ring FIFO with push, run read, delimited read, discard and unput.
// ----------------------------------------------------------------------------
// Timing: push, discard, unput and empty reads give their one result on the
//   cycle after the item is taken; a read fetches its first byte into the
//   memory's registered read data, then loads it into the output register.
// Throughput: one push, discard or unput item per cycle and one read byte per
//   cycle from the single memory read port, while out_stall is low; the next
//   item is taken once the run's last byte is in the output register.
// Reset: pointers and fill level clear, capacity goes to min(1024, DEPTH);
//   the byte memory is not cleared, and no clearing pass is run.
`default_nettype none

module byte_ring_fifo_with_delimiter_read_unit
	import brf_pkg::*;
#(
	parameter int DEPTH   = 1024,
	parameter int MAX_RUN = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration: capacity register
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_W-1:0]      cfg_wr_data,
	// input items
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [OP_W-1:0]       op,
	input  wire logic [BYTE_W-1:0]     data_byte,
	input  wire logic [CNT_W-1:0]      count,
	input  wire logic [BYTE_W-1:0]     delimiter,
	// result items
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [BYTE_W-1:0]     byte_out,
	output logic                       byte_valid,
	output logic                       last,
	output logic      [CNT_W-1:0]      moved,
	output logic      [OUT_FILL_W-1:0] fill_level
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	// ---------------------------------------------------------------- state
	state_t            state_q, state_nx;

	// run being streamed out by a read item
	logic [CNT_W-1:0]  run_n_q;
	logic [CNT_W-1:0]  run_k_q;
	logic [BYTE_W-1:0] delim_q;
	logic              delim_en_q;

	// output register
	logic                  out_valid_q;
	logic [BYTE_W-1:0]     byte_out_q;
	logic                  byte_valid_q;
	logic                  last_q;
	logic [CNT_W-1:0]      moved_q;
	logic [OUT_FILL_W-1:0] fill_level_q;

	// ----------------------------------------------------- pointer unit link
	ptr_cmd_t      cmd;
	logic [AW-1:0] rd_addr, rd_addr_next, wr_addr;
	logic [CW-1:0] fill, fill_next, cap;
	logic          push_ok;

	// ---------------------------------------------------------- memory link
	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [BYTE_W-1:0] mem_rdata;

	// ---------------------------------------------------------- misc. logic
	logic              out_free;
	logic              in_acc;
	logic [CNT_W-1:0]  cnt_clip;
	logic [CNT_W-1:0]  n_acc;
	logic [CNT_W-1:0]  k_inc;
	logic              run_stop;
	logic              load_out;
	logic              run_start;
	logic [BYTE_W-1:0] nx_byte;
	logic              nx_bvalid;
	logic              nx_last;
	logic [CNT_W-1:0]  nx_moved;

	brf_ptr #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ptr (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cmd          (cmd),
		.rd_addr      (rd_addr),
		.rd_addr_next (rd_addr_next),
		.wr_addr      (wr_addr),
		.fill         (fill),
		.fill_next    (fill_next),
		.cap          (cap),
		.push_ok      (push_ok)
	);

	brf_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_addr),
		.wdata (data_byte),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;

	// Clip the count to the run limit, then to the fill level.
	assign cnt_clip = (count > CNT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : count;
	assign n_acc    = (32'(cnt_clip) > 32'(fill)) ? CNT_W'(fill) : cnt_clip;

	// A run stops on its last byte or, for a delimited read, on the delimiter.
	assign k_inc    = run_k_q + CNT_W'(1);
	assign run_stop = (k_inc == run_n_q) || (delim_en_q && (mem_rdata == delim_q));

	// ---------------------------------------------------------- next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && (op == OP_READ || op == OP_READ_DELIM) && n_acc != '0) begin
					state_nx = ST_READ;
				end
			end
			ST_READ: begin
				if (out_free && run_stop) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// -------------------------------------------------------------- outputs
	always_comb begin
		cmd.kind  = UPD_NONE;
		cmd.n     = '0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = rd_addr;
		load_out  = 1'b0;
		run_start = 1'b0;
		nx_byte   = '0;
		nx_bvalid = 1'b0;
		nx_last   = 1'b1;
		nx_moved  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (op)
						OP_PUSH: begin
							load_out = 1'b1;
							if (push_ok) begin
								mem_we   = 1'b1;
								cmd.kind = UPD_PUSH;
								nx_moved = CNT_W'(1);
							end
						end
						OP_READ, OP_READ_DELIM: begin
							if (n_acc == '0) begin
								load_out = 1'b1;
							end else begin
								// fetch the head byte; results follow
								run_start = 1'b1;
								mem_re    = 1'b1;
							end
						end
						OP_DISCARD: begin
							load_out = 1'b1;
							cmd.kind = UPD_DISCARD;
							cmd.n    = n_acc;
							nx_moved = n_acc;
						end
						OP_UNPUT: begin
							load_out = 1'b1;
							cmd.kind = UPD_UNPUT;
							cmd.n    = n_acc;
							nx_moved = n_acc;
						end
						default: begin
							// undefined codes: no change, one empty result
							load_out = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				if (out_free) begin
					load_out  = 1'b1;
					cmd.kind  = UPD_POP;
					nx_byte   = mem_rdata;
					nx_bvalid = 1'b1;
					nx_last   = run_stop;
					nx_moved  = k_inc;
					// prefetch the next head byte while this one goes out
					if (!run_stop) begin
						mem_re    = 1'b1;
						mem_raddr = rd_addr_next;
					end
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------ registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			run_k_q     <= '0;
		end else begin
			state_q <= state_nx;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (run_start) begin
				run_k_q <= '0;
			end else if (state_q == ST_READ && out_free) begin
				run_k_q <= k_inc;
			end
		end
	end

	// Run parameters: latch at item acceptance, hold for the whole run.
	always_ff @(posedge clk) begin
		if (run_start) begin
			run_n_q    <= n_acc;
			delim_q    <= delimiter;
			delim_en_q <= (op == OP_READ_DELIM);
		end
	end

	// Result payload: load alongside the valid flag, hold while stalled.
	always_ff @(posedge clk) begin
		if (load_out) begin
			byte_out_q   <= nx_byte;
			byte_valid_q <= nx_bvalid;
			last_q       <= nx_last;
			moved_q      <= nx_moved;
			fill_level_q <= OUT_FILL_W'(fill_next);
		end
	end

	assign out_valid  = out_valid_q;
	assign byte_out   = byte_out_q;
	assign byte_valid = byte_valid_q;
	assign last       = last_q;
	assign moved      = moved_q;
	assign fill_level = fill_level_q;

	// ----------------------------------------------------------- assertions
	// A run only streams while bytes remain.
	a_read_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (fill != '0))
		else $error("read run active with an empty ring");

	// The byte counter stays below the clipped run length.
	a_run_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (run_k_q < run_n_q))
		else $error("read run overran its length");

	// The fill level never passes the capacity.
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= cap)
		else $error("fill level above capacity");

	// The read index always lies inside the ring.
	a_rd_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(rd_addr) < 32'(cap)))
		else $error("read index outside the ring");

	// A loaded result reports the fill level the pointer unit settles on.
	a_fill_report: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && !cfg_wr_en) |=> (fill_level == OUT_FILL_W'(fill)))
		else $error("reported fill level disagrees with pointer state");

endmodule

`default_nettype wire

// ===== rtl/brf_mem.sv =====
// ----------------------------------------------------------------------------
// brf_mem
// Byte storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_mem
	import brf_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [BYTE_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold the last read byte until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/brf_ptr.sv =====
// ----------------------------------------------------------------------------
// brf_ptr
// Capacity register, read index and fill level, with ring wrap arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ptr
	import brf_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int CW    = 11
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	input  wire ptr_cmd_t         cmd,
	output logic      [AW-1:0]    rd_addr,
	output logic      [AW-1:0]    rd_addr_next,
	output logic      [AW-1:0]    wr_addr,
	output logic      [CW-1:0]    fill,
	output logic      [CW-1:0]    fill_next,
	output logic      [CW-1:0]    cap,
	output logic                  push_ok
);

	localparam int SW      = CW + 1;
	localparam int CAP_RST = (CAP_RESET < DEPTH) ? CAP_RESET : DEPTH;

	logic [AW-1:0] rd_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] cap_q;

	logic [SW-1:0] rd_s, fill_s, cap_s, n_s, adv_s;
	logic [SW-1:0] wsum, wwrap, rsum, rwrap, fnext_s;
	logic [31:0]   cfg_ext;
	logic [CW-1:0] cap_clip;
	logic [AW-1:0] rd_nx;

	assign rd_s   = SW'(rd_q);
	assign fill_s = SW'(fill_q);
	assign cap_s  = SW'(cap_q);
	assign n_s    = SW'(cmd.n);

	// write slot: read index plus fill, folded once into the ring
	assign wsum  = rd_s + fill_s;
	assign wwrap = (wsum >= cap_s) ? (wsum - cap_s) : wsum;

	assign adv_s = (cmd.kind == UPD_POP) ? SW'(1) : n_s;
	assign rsum  = rd_s + adv_s;
	assign rwrap = (rsum >= cap_s) ? (rsum - cap_s) : rsum;

	always_comb begin
		unique case (cmd.kind)
			UPD_PUSH:    fnext_s = fill_s + SW'(1);
			UPD_POP:     fnext_s = fill_s - SW'(1);
			UPD_DISCARD,
			UPD_UNPUT:   fnext_s = fill_s - n_s;
			default:     fnext_s = fill_s;
		endcase
	end

	always_comb begin
		if (fnext_s == '0) begin
			rd_nx = '0;
		end else if (cmd.kind == UPD_POP || cmd.kind == UPD_DISCARD) begin
			rd_nx = rwrap[AW-1:0];
		end else begin
			rd_nx = rd_q;
		end
	end

	always_comb begin
		cfg_ext = 32'(cfg_wr_data);
		if (cfg_ext == 32'd0) begin
			cap_clip = CW'(1);
		end else if (cfg_ext > 32'(DEPTH)) begin
			cap_clip = CW'(DEPTH);
		end else begin
			cap_clip = CW'(cfg_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= '0;
			fill_q <= '0;
			cap_q  <= CW'(CAP_RST);
		end else if (cfg_wr_en) begin
			rd_q   <= '0;
			fill_q <= '0;
			cap_q  <= cap_clip;
		end else begin
			rd_q   <= rd_nx;
			fill_q <= CW'(fnext_s);
		end
	end

	assign rd_addr      = rd_q;
	assign rd_addr_next = rd_nx;
	assign wr_addr      = wwrap[AW-1:0];
	assign fill         = fill_q;
	assign fill_next    = CW'(fnext_s);
	assign cap          = cap_q;
	assign push_ok      = (fill_q < cap_q);

endmodule

`default_nettype wire

// ===== bench/tb_byte_ring_fifo_with_delimiter_read_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo_with_delimiter_read_unit
// Self-checking bench for the byte ring FIFO: directed corner items, then
// random push/read/discard/unput traffic over several ring capacities, with
// bursty input, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------

import brf_pkg::*;

// one result item as seen on the output port
typedef struct packed {
	logic [BYTE_W-1:0]     byte_out;
	logic                  byte_valid;
	logic                  last;
	logic [CNT_W-1:0]      moved;
	logic [OUT_FILL_W-1:0] fill_level;
} fifo_result_t;

// Shadow copy of the ring, pointers and capacity, plus the queue of results
// still owed by the block.
class ring_fifo_scoreboard;
	localparam int unsigned RING_DEPTH = 1024;
	localparam int unsigned RUN_LIMIT  = 64;

	logic [BYTE_W-1:0] ring [RING_DEPTH];
	int unsigned       rd_ptr;
	int unsigned       wr_ptr;
	int unsigned       cap;
	fifo_result_t      owed_results[$];
	int                failures;

	function new();
		rd_ptr   = 0;
		wr_ptr   = 0;
		cap      = CAP_RESET;
		failures = 0;
	endfunction

	function int unsigned fill_now();
		return wr_ptr - rd_ptr;
	endfunction

	// byte k places behind the head
	function logic [BYTE_W-1:0] peek(int unsigned k);
		return ring[(rd_ptr + k) % cap];
	endfunction

	// pointers go back to zero when empty, else the head wraps into range
	function void settle();
		int unsigned fill;
		fill = wr_ptr - rd_ptr;
		if (fill == 0) begin
			rd_ptr = 0;
			wr_ptr = 0;
		end else begin
			rd_ptr = rd_ptr % cap;
			wr_ptr = rd_ptr + fill;
		end
	endfunction

	function void owe(logic [BYTE_W-1:0] b, logic v, logic lst, int unsigned mv);
		fifo_result_t r;
		r.byte_out   = b;
		r.byte_valid = v;
		r.last       = lst;
		r.moved      = mv[CNT_W-1:0];
		r.fill_level = OUT_FILL_W'(fill_now());
		owed_results.push_back(r);
	endfunction

	function void set_capacity(logic [CFG_W-1:0] v);
		cap = 32'(v);
		if (cap < 1) cap = 1;
		if (cap > RING_DEPTH) cap = RING_DEPTH;
		rd_ptr = 0;
		wr_ptr = 0;
	endfunction

	// apply one accepted item and queue the results it produces
	function void take_item(logic [OP_W-1:0] opc, logic [BYTE_W-1:0] d,
			logic [CNT_W-1:0] cnt, logic [BYTE_W-1:0] dl);
		int unsigned       fill;
		int unsigned       n;
		int unsigned       k;
		logic [BYTE_W-1:0] b;
		bit                stop;
		fill = fill_now();
		n    = 32'(cnt);
		stop = 0;
		if (n > RUN_LIMIT) n = RUN_LIMIT;
		if (n > fill) n = fill;
		case (opc)
			OP_PUSH: begin
				if (fill < cap) begin
					ring[wr_ptr % cap] = d;
					wr_ptr++;
					settle();
					owe('0, 1'b0, 1'b1, 1);
				end else begin
					owe('0, 1'b0, 1'b1, 0);
				end
			end
			OP_READ, OP_READ_DELIM: begin
				if (n == 0) begin
					owe('0, 1'b0, 1'b1, 0);
				end else begin
					for (k = 0; k < n && !stop; k++) begin
						b    = ring[rd_ptr % cap];
						stop = (k + 1 == n) || (opc == OP_READ_DELIM && b == dl);
						rd_ptr++;
						settle();
						owe(b, 1'b1, stop, k + 1);
					end
				end
			end
			OP_DISCARD: begin
				rd_ptr += n;
				settle();
				owe('0, 1'b0, 1'b1, n);
			end
			OP_UNPUT: begin
				wr_ptr -= n;
				settle();
				owe('0, 1'b0, 1'b1, n);
			end
			default: begin
				owe('0, 1'b0, 1'b1, 0);
			end
		endcase
	endfunction

	function void report(string what);
		failures++;
		if (failures <= 10) $display("%0t: %s", $time, what);
	endfunction

	function void check_result(fifo_result_t got);
		fifo_result_t want;
		if (owed_results.size() == 0) begin
			report($sformatf("unexpected result byte %02h valid %0b last %0b moved %0d fill %0d",
				got.byte_out, got.byte_valid, got.last, got.moved, got.fill_level));
			return;
		end
		want = owed_results.pop_front();
		if (got.byte_out !== want.byte_out || got.byte_valid !== want.byte_valid ||
				got.last !== want.last || got.moved !== want.moved ||
				got.fill_level !== want.fill_level)
			report($sformatf({"result mismatch: exp byte %02h valid %0b last %0b moved %0d",
				" fill %0d, got byte %02h valid %0b last %0b moved %0d fill %0d"},
				want.byte_out, want.byte_valid, want.last, want.moved, want.fill_level,
				got.byte_out, got.byte_valid, got.last, got.moved, got.fill_level));
	endfunction
endclass

module tb_byte_ring_fifo_with_delimiter_read_unit;

	localparam int     CLK_PERIOD    = 12;
	localparam int     HOLD_CYCLES   = 400;
	localparam int     SETTLE_CYCLES = 8;
	localparam longint LIMIT_CYCLES  = 1000000;

	// op codes the block leaves undefined
	localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_W-1:0]      cfg_wr_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [OP_W-1:0]       op;
	logic [BYTE_W-1:0]     data_byte;
	logic [CNT_W-1:0]      count;
	logic [BYTE_W-1:0]     delimiter;
	logic                  out_valid;
	logic                  out_stall;
	logic [BYTE_W-1:0]     byte_out;
	logic                  byte_valid;
	logic                  last;
	logic [CNT_W-1:0]      moved;
	logic [OUT_FILL_W-1:0] fill_level;

	ring_fifo_scoreboard sb;
	int                  burst_left;
	bit                  hold_off_req;

	byte_ring_fifo_with_delimiter_read_unit #(
		.DEPTH   (1024),
		.MAX_RUN (64)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.data_byte   (data_byte),
		.count       (count),
		.delimiter   (delimiter),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.byte_out    (byte_out),
		.byte_valid  (byte_valid),
		.last        (last),
		.moved       (moved),
		.fill_level  (fill_level)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("byte_ring_fifo_with_delimiter_read_unit regression: fail");
		$finish;
	end

	// Result monitor: sample at the rising edge, before the block's flops move.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({byte_out, byte_valid, last, moved, fill_level});
	end

	// Receiver: stall patterns in short spans, with one long hold-off on
	// request. Each span sets out_stall once per falling edge.
	initial begin : receiver
		int mode;
		int span;
		out_stall = 1'b0;
		forever begin
			if (hold_off_req) begin
				hold_off_req = 0;
				// hold the output long enough to back up the ring and the input
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					out_stall = 1'b1;
				end
			end
			mode = $urandom_range(3);
			span = $urandom_range(40, 4);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0:       out_stall = 1'b0;
					1:       out_stall = ($urandom_range(1) == 0);
					2:       out_stall = ($urandom_range(4) != 0);
					default: out_stall = ($urandom_range(4) == 0);
				endcase
			end
		end
	end

	// Offer one item and hold it until the block takes it. Enter and leave
	// at a falling edge. Bursts of random length are separated by random gaps,
	// possibly empty; valid stays high across items within a burst.
	task automatic offer_item(input logic [OP_W-1:0] o, input logic [BYTE_W-1:0] d,
			input logic [CNT_W-1:0] c, input logic [BYTE_W-1:0] dl);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(5) == 0) begin
				burst_left = $urandom_range(80, 40);
				gap        = 0;
			end else begin
				burst_left = $urandom_range(24, 1);
				gap        = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
			end
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid  = 1'b1;
		op        = o;
		data_byte = d;
		count     = c;
		delimiter = dl;
		do @(posedge clk); while (in_stall);
		sb.take_item(o, d, c, dl);
		burst_left--;
		@(negedge clk);
	endtask

	// Drop valid, wait for every owed result, then let the pipe go quiet.
	task automatic drain_results();
		in_valid   = 1'b0;
		burst_left = 0;
		while (sb.owed_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CFG_W-1:0] v);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = v;
		@(posedge clk);
		sb.set_capacity(v);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Mostly small counts; now and then a long run or one past the run limit.
	function automatic logic [CNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 70) return CNT_W'($urandom_range(12, 1));
		if (r < 90) return CNT_W'($urandom_range(64, 13));
		return CNT_W'($urandom_range(127, 65));
	endfunction

	// random byte for a payload field
	function automatic logic [BYTE_W-1:0] pick_byte();
		return BYTE_W'($urandom_range(255));
	endfunction

	// One random item, biased by the current fill so that the ring both fills
	// and empties. Delimited reads mostly aim at a byte that is really queued.
	task automatic offer_random_item();
		int unsigned       fill;
		int                r;
		int                push_share;
		logic [BYTE_W-1:0] dl;
		fill       = sb.fill_now();
		push_share = (fill * 2 < sb.cap) ? 55 : 35;
		r          = $urandom_range(99);
		dl         = pick_byte();
		if (r < push_share) begin
			offer_item(OP_PUSH, pick_byte(), pick_count(), dl);
		end else if (r < push_share + 20) begin
			offer_item(OP_READ, pick_byte(), pick_count(), dl);
		end else if (r < push_share + 38) begin
			if (fill > 0 && $urandom_range(9) < 7)
				dl = sb.peek($urandom_range(fill - 1));
			offer_item(OP_READ_DELIM, pick_byte(), pick_count(), dl);
		end else if (r < push_share + 45) begin
			offer_item(OP_DISCARD, pick_byte(), pick_count(), dl);
		end else if (r < push_share + 52) begin
			offer_item(OP_UNPUT, pick_byte(), pick_count(), dl);
		end else begin
			// noise: spare op codes and zero counts
			case ($urandom_range(3))
				0: offer_item(OP_SPARE_5, pick_byte(), CNT_W'($urandom_range(127)), dl);
				1: offer_item(OP_SPARE_6, pick_byte(), CNT_W'($urandom_range(127)), dl);
				2: offer_item(OP_SPARE_7, pick_byte(), CNT_W'($urandom_range(127)), dl);
				default: offer_item($urandom_range(1) ? OP_READ : OP_READ_DELIM,
					pick_byte(), '0, dl);
			endcase
		end
	endtask

	initial begin : stimulus
		logic [CFG_W-1:0] caps [9];
		int               p;
		int               n_items;
		sb           = new();
		burst_left   = 0;
		hold_off_req = 0;
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		in_valid     = 1'b0;
		op           = OP_PUSH;
		data_byte    = '0;
		count        = '0;
		delimiter    = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty ring at the reset capacity.
		offer_item(OP_READ, 8'h00, 7'd5, 8'h00);
		offer_item(OP_READ_DELIM, 8'h00, 7'd5, 8'h00);
		offer_item(OP_DISCARD, 8'h00, 7'd3, 8'h00);
		offer_item(OP_UNPUT, 8'h00, 7'd3, 8'h00);
		// byte extremes in, then a zero-count read
		offer_item(OP_PUSH, 8'h00, 7'd1, 8'h00);
		offer_item(OP_PUSH, 8'hFF, 7'd1, 8'h00);
		offer_item(OP_PUSH, 8'hA5, 7'd1, 8'h00);
		offer_item(OP_PUSH, 8'h5A, 7'd1, 8'h00);
		offer_item(OP_PUSH, 8'h0D, 7'd1, 8'h00);
		offer_item(OP_READ, 8'h00, 7'd0, 8'h00);
		// count past the run limit, stopping on the delimiter after two bytes
		offer_item(OP_READ_DELIM, 8'h00, 7'd127, 8'hFF);
		offer_item(OP_UNPUT, 8'h00, 7'd1, 8'h00);
		offer_item(OP_DISCARD, 8'h00, 7'd1, 8'h00);
		offer_item(OP_READ, 8'h00, 7'd64, 8'h00);
		// spare op codes leave the ring alone
		offer_item(OP_SPARE_5, 8'hFF, 7'd127, 8'hFF);
		offer_item(OP_SPARE_6, 8'hFF, 7'd127, 8'hFF);
		offer_item(OP_SPARE_7, 8'hFF, 7'd127, 8'hFF);
		drain_results();

		// Capacity zero clamps to one byte: second push is refused when full.
		write_capacity(11'd0);
		offer_item(OP_PUSH, 8'h11, 7'd1, 8'h00);
		offer_item(OP_PUSH, 8'h22, 7'd1, 8'h00);
		offer_item(OP_READ_DELIM, 8'h00, 7'd1, 8'h11);
		drain_results();

		// Oversized capacity clamps to the full depth; unput more than held.
		write_capacity(11'd2047);
		offer_item(OP_PUSH, 8'hFF, 7'd1, 8'h00);
		offer_item(OP_UNPUT, 8'h00, 7'd100, 8'h00);
		drain_results();

		// Random phases over a spread of capacities, extremes included.
		caps = '{11'd3, 11'd17, 11'd1024, 11'd64, 11'd1, 11'd200, 11'd2, 11'd1500, 11'd5};
		for (p = 0; p < 9; p++) begin
			write_capacity(caps[p]);
			// back up the whole path once, while input keeps coming
			if (p == 1) hold_off_req = 1;
			n_items = $urandom_range(45, 32);
			repeat (n_items) offer_random_item();
			drain_results();
		end

		if (sb.owed_results.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.owed_results.size()));
		if (sb.failures == 0) begin
			$display("byte_ring_fifo_with_delimiter_read_unit regression: pass");
		end else begin
			$display("byte_ring_fifo_with_delimiter_read_unit regression: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/brf_pkg.sv
rtl/brf_mem.sv
rtl/brf_ptr.sv
rtl/byte_ring_fifo_with_delimiter_read_unit.sv
bench/tb_byte_ring_fifo_with_delimiter_read_unit.sv
